### design/pabc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// polygon area, bounding box and centroid block. Depends on nothing.
`timescale 1ns / 1ps

package pabc_pkg;

   // Coordinate and vertex-count limits
   localparam int COORD_BITS   = 24;
   localparam int MAX_VERTICES = 1024;

   // Derived widths
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int CROSS_BITS = 59;
   localparam int AREA_BITS  = 57;
   localparam int SUM_BITS   = 35;
   localparam int TOTAL_BITS = $clog2(MAX_VERTICES + 1);
   localparam int CNT_BITS   = $clog2(MAX_VERTICES + 2);
   localparam int DIV_STEPS  = SUM_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   // Result status codes, highest priority first: overflow, short, zero area
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_ZERO     = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;    // take the incoming vertex word
      logic mul;        // register both cross-product terms
      logic acc;        // fold the products and the vertex into the sums
      logic close;      // use the first vertex as the edge end point
      logic div_start;  // load both centroid dividers
      logic div_step;   // one quotient bit in each divider
      logic load;       // move the finished result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic last;       // captured vertex closes the polygon
      logic out_busy;   // output register holds a word that is not taken
   } stat_type;

endpackage

### design/pabc_div.sv
// Bit-serial restoring divider lane: signed running sum over vertex count,
// truncated toward zero. Depends on pabc_pkg.
`timescale 1ns / 1ps

module pabc_div (
   input  logic                                  clock,
   input  logic                                  start,
   input  logic                                  step,
   input  logic signed [pabc_pkg::SUM_BITS-1:0]  dividend,
   input  logic [pabc_pkg::TOTAL_BITS-1:0]       divisor,
   output logic signed [pabc_pkg::COORD_BITS-1:0] quotient
);
   import pabc_pkg::*;

   logic [SUM_BITS-1:0]   quo_ff, quo_in;
   logic [TOTAL_BITS-1:0] rem_ff, rem_in;
   logic [TOTAL_BITS-1:0] dsr_ff, dsr_in;
   logic                  neg_ff, neg_in;
   logic [TOTAL_BITS+1:0] trial;
   logic [SUM_BITS-1:0]   mag;
   logic [SUM_BITS-1:0]   signed_quo;

   // Magnitude of the dividend; the sign is restored at the end
   assign mag = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;

   // Trial subtract of the divisor from the shifted partial remainder
   assign trial = {1'b0, rem_ff, quo_ff[SUM_BITS-1]} - {2'b00, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      if (start) begin
         quo_in = mag;
         rem_in = '0;
         dsr_in = divisor;
         neg_in = dividend[SUM_BITS-1];
      end else if (step) begin
         if (!trial[TOTAL_BITS+1]) begin
            rem_in = trial[TOTAL_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[TOTAL_BITS-2:0], quo_ff[SUM_BITS-1]};
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // Apply the sign and keep the coordinate width
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[COORD_BITS-1:0];

endmodule

### design/pabc_ctrl.sv
// Controller state machine: sequences capture, multiply, accumulate, closing
// edge, centroid division and result load. Depends on pabc_pkg.
`timescale 1ns / 1ps

module pabc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pabc_pkg::stat_type  stat,
   output pabc_pkg::cmd_type   cmd
);
   import pabc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_CMUL,
      S_CACC,
      S_DIVLD,
      S_DIV,
      S_LOAD
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 req_stall_ff, req_stall_in;

   // Decode commands and the next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid && !req_stall_ff;
            if (cmd.capture) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.last ? S_CMUL : S_IDLE;
         end
         S_CMUL: begin
            cmd.mul   = 1'b1;
            cmd.close = 1'b1;
            state_in  = S_CACC;
         end
         S_CACC: begin
            cmd.acc   = 1'b1;
            cmd.close = 1'b1;
            state_in  = S_DIVLD;
         end
         S_DIVLD: begin
            cmd.div_start = 1'b1;
            step_in       = STEP_BITS'(DIV_STEPS - 1);
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = !stat.out_busy;
            if (cmd.load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      req_stall_in = (state_in != S_IDLE);
   end

   // Hold state, step count and the registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

   // Only one datapath action at a time
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mul, cmd.acc, cmd.div_start, cmd.div_step, cmd.load}))
      else $error("pabc_ctrl: overlapping datapath commands");

   // An accepted word goes straight to the multiply step
   a_accept_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_MUL))
      else $error("pabc_ctrl: accepted vertex not multiplied next");

   // Never overwrite a result that is still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !stat.out_busy)
      else $error("pabc_ctrl: load into a busy output register");

endmodule

### design/pabc_dp.sv
// Datapath: vertex capture, cross-product multipliers, running sums, bounds,
// centroid dividers and the result register. Depends on pabc_pkg, pabc_div.
`timescale 1ns / 1ps

module pabc_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pabc_pkg::cmd_type                      cmd,
   output pabc_pkg::stat_type                     stat,
   input  logic signed [pabc_pkg::COORD_BITS-1:0] req_vertex_x,
   input  logic signed [pabc_pkg::COORD_BITS-1:0] req_vertex_y,
   input  logic                                   req_last_vertex,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic [pabc_pkg::AREA_BITS-1:0]         rsp_area,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_centre_x,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_centre_y,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_box_centre_x,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_box_centre_y,
   output logic [pabc_pkg::COORD_BITS-1:0]        rsp_box_width,
   output logic [pabc_pkg::COORD_BITS-1:0]        rsp_box_height,
   output logic [pabc_pkg::TOTAL_BITS-1:0]        rsp_vertex_total
);
   import pabc_pkg::*;

   // Captured vertex
   logic signed [COORD_BITS-1:0] vx_ff, vy_ff;
   logic                         last_ff;

   // Polygon state
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [SUM_BITS-1:0]   sum_x_ff, sum_y_ff;
   logic [CROSS_BITS-1:0]        cross_ff;
   logic [CNT_BITS-1:0]          count_ff, count_in;

   // Cross-product terms
   logic signed [COORD_BITS-1:0] end_x, end_y;
   logic signed [PROD_BITS-1:0]  prod_a_ff, prod_b_ff;
   logic [PROD_BITS:0]           diff;
   logic [CROSS_BITS-1:0]        diff_ext;

   // Result terms
   logic                         overflow;
   logic [TOTAL_BITS-1:0]        total;
   logic [CROSS_BITS-1:0]        cross_mag;
   logic [COORD_BITS:0]          box_sum_x, box_sum_y;
   logic signed [COORD_BITS-1:0] quo_x, quo_y;
   status_type                   status;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   status_ff;
   logic [AREA_BITS-1:0]         area_ff;
   logic signed [COORD_BITS-1:0] centre_x_ff, centre_y_ff, box_cx_ff, box_cy_ff;
   logic [COORD_BITS-1:0]        box_w_ff, box_h_ff;
   logic [TOTAL_BITS-1:0]        total_ff;

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vx_ff   <= req_vertex_x;
         vy_ff   <= req_vertex_y;
         last_ff <= req_last_vertex;
      end
   end

   // Edge end point: this vertex, or the first one for the closing edge
   assign end_x = cmd.close ? first_x_ff : vx_ff;
   assign end_y = cmd.close ? first_y_ff : vy_ff;

   // Register both products of prev x end - end x prev
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_a_ff <= prev_x_ff * end_y;
         prod_b_ff <= end_x * prev_y_ff;
      end
   end

   assign diff     = {prod_a_ff[PROD_BITS-1], prod_a_ff} - {prod_b_ff[PROD_BITS-1], prod_b_ff};
   assign diff_ext = {{(CROSS_BITS-PROD_BITS-1){diff[PROD_BITS]}}, diff};

   // Vertex count: saturate one past the limit to flag overflow
   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         count_in = '0;
      end else if (cmd.acc && !cmd.close) begin
         if (count_ff < CNT_BITS'(MAX_VERTICES)) begin
            count_in = count_ff + 1'b1;
         end else begin
            count_in = CNT_BITS'(MAX_VERTICES + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Accumulate: reload on the first vertex, drop vertices past the limit
   always_ff @(posedge clock) begin
      if (cmd.acc && cmd.close) begin
         cross_ff <= cross_ff + diff_ext;
      end else if (cmd.acc && count_ff == '0) begin
         first_x_ff <= vx_ff;
         first_y_ff <= vy_ff;
         prev_x_ff  <= vx_ff;
         prev_y_ff  <= vy_ff;
         min_x_ff   <= vx_ff;
         max_x_ff   <= vx_ff;
         min_y_ff   <= vy_ff;
         max_y_ff   <= vy_ff;
         sum_x_ff   <= {{(SUM_BITS-COORD_BITS){vx_ff[COORD_BITS-1]}}, vx_ff};
         sum_y_ff   <= {{(SUM_BITS-COORD_BITS){vy_ff[COORD_BITS-1]}}, vy_ff};
         cross_ff   <= '0;
      end else if (cmd.acc && count_ff < CNT_BITS'(MAX_VERTICES)) begin
         cross_ff  <= cross_ff + diff_ext;
         sum_x_ff  <= sum_x_ff + {{(SUM_BITS-COORD_BITS){vx_ff[COORD_BITS-1]}}, vx_ff};
         sum_y_ff  <= sum_y_ff + {{(SUM_BITS-COORD_BITS){vy_ff[COORD_BITS-1]}}, vy_ff};
         prev_x_ff <= vx_ff;
         prev_y_ff <= vy_ff;
         if (vx_ff < min_x_ff) begin
            min_x_ff <= vx_ff;
         end
         if (vx_ff > max_x_ff) begin
            max_x_ff <= vx_ff;
         end
         if (vy_ff < min_y_ff) begin
            min_y_ff <= vy_ff;
         end
         if (vy_ff > max_y_ff) begin
            max_y_ff <= vy_ff;
         end
      end
   end

   // Vertex total used for the mean and reported
   assign overflow = (count_ff > CNT_BITS'(MAX_VERTICES));
   assign total    = overflow ? TOTAL_BITS'(MAX_VERTICES) : TOTAL_BITS'(count_ff);

   // Centroid dividers, one lane per axis
   pabc_div u_div_x (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_x_ff),
      .divisor  (total),
      .quotient (quo_x)
   );

   pabc_div u_div_y (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_y_ff),
      .divisor  (total),
      .quotient (quo_y)
   );

   // Area magnitude, box terms and status
   assign cross_mag = cross_ff[CROSS_BITS-1] ? (~cross_ff + 1'b1) : cross_ff;
   assign box_sum_x = {max_x_ff[COORD_BITS-1], max_x_ff} + {min_x_ff[COORD_BITS-1], min_x_ff};
   assign box_sum_y = {max_y_ff[COORD_BITS-1], max_y_ff} + {min_y_ff[COORD_BITS-1], min_y_ff};

   always_comb begin
      if (overflow) begin
         status = STATUS_OVERFLOW;
      end else if (total < TOTAL_BITS'(3)) begin
         status = STATUS_SHORT;
      end else if (cross_ff == '0) begin
         status = STATUS_ZERO;
      end else begin
         status = STATUS_OK;
      end
   end

   // Output word valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff   <= status;
         area_ff     <= cross_mag[AREA_BITS:1];
         centre_x_ff <= quo_x;
         centre_y_ff <= quo_y;
         box_cx_ff   <= box_sum_x[COORD_BITS:1];
         box_cy_ff   <= box_sum_y[COORD_BITS:1];
         box_w_ff    <= max_x_ff - min_x_ff;
         box_h_ff    <= max_y_ff - min_y_ff;
         total_ff    <= total;
      end
   end

   assign stat.last     = last_ff;
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_area         = area_ff;
   assign rsp_centre_x     = centre_x_ff;
   assign rsp_centre_y     = centre_y_ff;
   assign rsp_box_centre_x = box_cx_ff;
   assign rsp_box_centre_y = box_cy_ff;
   assign rsp_box_width    = box_w_ff;
   assign rsp_box_height   = box_h_ff;
   assign rsp_vertex_total = total_ff;

   // Count never passes the overflow mark
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_VERTICES + 1))
      else $error("pabc_dp: vertex count out of range");

   // A load leaves a valid word and a cleared polygon
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (rsp_valid_ff && count_ff == '0))
      else $error("pabc_dp: load did not present a word and clear the count");

   // Bounds stay ordered once a vertex is in
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_x_ff <= max_x_ff && min_y_ff <= max_y_ff))
      else $error("pabc_dp: bounding box inverted");

endmodule

### design/polygon_area_bbox_centroid.sv
// Top level of the polygon area, bounding box and centroid block: joins the
// controller and the datapath. Depends on pabc_pkg, pabc_ctrl, pabc_dp.
`timescale 1ns / 1ps

// Vertices of one polygon arrive one word at a time in signed Q15.8, with
// req_last_vertex set on the closing vertex; one result word follows each
// closing vertex. Each vertex is accepted, multiplied through the pair of
// 24x24 multipliers and accumulated; req_stall is high while a word is
// multiplied and accumulated. The closing vertex then adds the closing
// edge, a load of the centroid dividers and the bit-serial dividers (one
// quotient bit per cycle), then a load of the output register, with
// req_stall high throughout. The output register lets the next polygon
// start while the result waits; a second result waits until the first is
// taken. Vertices past 1024 are counted only for the overflow status. The
// area is the absolute shoelace sum halved (Q.16), the centre is the vertex
// mean truncated toward zero.
module polygon_area_bbox_centroid (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pabc_pkg::COORD_BITS-1:0] req_vertex_x,
   input  logic signed [pabc_pkg::COORD_BITS-1:0] req_vertex_y,
   input  logic                                   req_last_vertex,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic [pabc_pkg::AREA_BITS-1:0]         rsp_area,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_centre_x,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_centre_y,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_box_centre_x,
   output logic signed [pabc_pkg::COORD_BITS-1:0] rsp_box_centre_y,
   output logic [pabc_pkg::COORD_BITS-1:0]        rsp_box_width,
   output logic [pabc_pkg::COORD_BITS-1:0]        rsp_box_height,
   output logic [pabc_pkg::TOTAL_BITS-1:0]        rsp_vertex_total
);
   import pabc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence each vertex and the end-of-polygon work
   pabc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Accumulate, divide and hold the result word
   pabc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_area         (rsp_area),
      .rsp_centre_x     (rsp_centre_x),
      .rsp_centre_y     (rsp_centre_y),
      .rsp_box_centre_x (rsp_box_centre_x),
      .rsp_box_centre_y (rsp_box_centre_y),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_vertex_total (rsp_vertex_total)
   );

endmodule

### test/testbench.sv
// Self-checking testbench for polygon_area_bbox_centroid: streams polygons of
// vertex words, predicts each result word and checks it field by field.
// Depends on pabc_pkg and the polygon_area_bbox_centroid RTL.
`timescale 1ns / 1ps

module testbench;
   import pabc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_ITEMS = 450;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum int {
      FLAVOR_SMALL,
      FLAVOR_FULL,
      FLAVOR_EDGE,
      FLAVOR_LINE
   } flavor_type;

   typedef struct packed {
      status_type                    status;
      logic [AREA_BITS-1:0]          area;
      logic [COORD_BITS-1:0]         centre_x;
      logic [COORD_BITS-1:0]         centre_y;
      logic [COORD_BITS-1:0]         box_centre_x;
      logic [COORD_BITS-1:0]         box_centre_y;
      logic [COORD_BITS-1:0]         box_width;
      logic [COORD_BITS-1:0]         box_height;
      logic [TOTAL_BITS-1:0]         vertex_total;
   } polygon_result_type;

   // Running shoelace sums and bounds of the open polygon, plus the results
   // still owed by the block.
   class shoelace_tracker;
      longint first_x, first_y, prev_x, prev_y;
      longint sum_x, sum_y, min_x, max_x, min_y, max_y;
      logic [CROSS_BITS-1:0] cross_acc;
      int count;
      polygon_result_type results_due[$];
      int errors;
      int words_seen;

      function new();
         errors = 0;
         words_seen = 0;
         clear();
      endfunction

      function void clear();
         first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
         sum_x = 0; sum_y = 0;
         min_x = 0; max_x = 0; min_y = 0; max_y = 0;
         cross_acc = '0;
         count = 0;
      endfunction

      // Add the edge cross product a x b, wrapping at the sum width
      function void add_edge(longint ax, longint ay, longint bx, longint by);
         longint d;
         d = ax * by - bx * ay;
         cross_acc = cross_acc + d[CROSS_BITS-1:0];
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void take_vertex(logic signed [COORD_BITS-1:0] vx,
                                logic signed [COORD_BITS-1:0] vy, logic last);
         longint x, y, s, q;
         logic [63:0] mag;
         int total;
         logic over;
         polygon_result_type r;
         x = vx;
         y = vy;
         // Accumulate up to the vertex limit; past it only note the overflow
         if (count == 0) begin
            first_x = x; first_y = y;
            min_x = x; max_x = x; min_y = y; max_y = y;
            sum_x = x; sum_y = y;
            prev_x = x; prev_y = y;
            count = 1;
         end else if (count < MAX_VERTICES) begin
            add_edge(prev_x, prev_y, x, y);
            sum_x += x;
            sum_y += y;
            if (x < min_x) min_x = x;
            if (x > max_x) max_x = x;
            if (y < min_y) min_y = y;
            if (y > max_y) max_y = y;
            prev_x = x; prev_y = y;
            count++;
         end else begin
            count = MAX_VERTICES + 1;
         end
         if (!last) return;

         // Close back to the first vertex and build the result word
         add_edge(prev_x, prev_y, first_x, first_y);
         over = (count > MAX_VERTICES);
         total = over ? MAX_VERTICES : count;
         s = longint'({{(64-CROSS_BITS){cross_acc[CROSS_BITS-1]}}, cross_acc});
         mag = (s < 0) ? -s : s;
         mag = mag >> 1;
         r.area = mag[AREA_BITS-1:0];
         if (over) r.status = STATUS_OVERFLOW;
         else if (total < 3) r.status = STATUS_SHORT;
         else if (s == 0) r.status = STATUS_ZERO;
         else r.status = STATUS_OK;
         q = sum_x / longint'(total);
         r.centre_x = q[COORD_BITS-1:0];
         q = sum_y / longint'(total);
         r.centre_y = q[COORD_BITS-1:0];
         q = (max_x + min_x) >>> 1;
         r.box_centre_x = q[COORD_BITS-1:0];
         q = (max_y + min_y) >>> 1;
         r.box_centre_y = q[COORD_BITS-1:0];
         q = max_x - min_x;
         r.box_width = q[COORD_BITS-1:0];
         q = max_y - min_y;
         r.box_height = q[COORD_BITS-1:0];
         r.vertex_total = total[TOTAL_BITS-1:0];
         results_due.push_back(r);
         clear();
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10)
            $display("word %0d %s: expected 0x%0h, got 0x%0h", words_seen, what, want, got);
      endfunction

      function void check_word(polygon_result_type got);
         polygon_result_type want;
         words_seen++;
         if (results_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("word %0d arrived with nothing due, area 0x%0h", words_seen, got.area);
            return;
         end
         want = results_due.pop_front();
         if (want.status !== got.status) flag("status", want.status, got.status);
         if (want.area !== got.area) flag("area", want.area, got.area);
         if (want.centre_x !== got.centre_x) flag("centre_x", want.centre_x, got.centre_x);
         if (want.centre_y !== got.centre_y) flag("centre_y", want.centre_y, got.centre_y);
         if (want.box_centre_x !== got.box_centre_x)
            flag("box_centre_x", want.box_centre_x, got.box_centre_x);
         if (want.box_centre_y !== got.box_centre_y)
            flag("box_centre_y", want.box_centre_y, got.box_centre_y);
         if (want.box_width !== got.box_width)
            flag("box_width", want.box_width, got.box_width);
         if (want.box_height !== got.box_height)
            flag("box_height", want.box_height, got.box_height);
         if (want.vertex_total !== got.vertex_total)
            flag("vertex_total", want.vertex_total, got.vertex_total);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_BITS-1:0] req_vertex_x = '0;
   logic signed [COORD_BITS-1:0] req_vertex_y = '0;
   logic req_last_vertex = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [AREA_BITS-1:0] rsp_area;
   logic signed [COORD_BITS-1:0] rsp_centre_x;
   logic signed [COORD_BITS-1:0] rsp_centre_y;
   logic signed [COORD_BITS-1:0] rsp_box_centre_x;
   logic signed [COORD_BITS-1:0] rsp_box_centre_y;
   logic [COORD_BITS-1:0] rsp_box_width;
   logic [COORD_BITS-1:0] rsp_box_height;
   logic [TOTAL_BITS-1:0] rsp_vertex_total;

   shoelace_tracker tracker = new();
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   int cycle_count = 0;

   polygon_area_bbox_centroid uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_area         (rsp_area),
      .rsp_centre_x     (rsp_centre_x),
      .rsp_centre_y     (rsp_centre_y),
      .rsp_box_centre_x (rsp_box_centre_x),
      .rsp_box_centre_y (rsp_box_centre_y),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_vertex_total (rsp_vertex_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one vertex word, idling first at random; valid stays high
   // across back-to-back words.
   task automatic send_vertex(input logic signed [COORD_BITS-1:0] vx,
                              input logic signed [COORD_BITS-1:0] vy, input logic last);
      int gap;
      gap = 0;
      if (!calm)
         while ($urandom_range(99) < 34) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_last_vertex <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_vertex(vx, vy, last);
   endtask

   function automatic logic signed [COORD_BITS-1:0] pick_coord(flavor_type f);
      logic signed [COORD_BITS-1:0] c;
      case (f)
         FLAVOR_SMALL: begin
            c = COORD_BITS'($urandom_range(4000));
            c = c - COORD_BITS'(2000);
         end
         FLAVOR_EDGE: begin
            case ($urandom_range(4))
               0: c = COORD_MIN;
               1: c = COORD_MAX;
               2: c = '0;
               3: c = '1;
               default: c = COORD_BITS'(1);
            endcase
         end
         default: c = COORD_BITS'($urandom());
      endcase
      return c;
   endfunction

   // Send a polygon of n vertices; a line polygon has all vertices on y = x
   task automatic send_polygon(input int n, input flavor_type f);
      int i;
      logic signed [COORD_BITS-1:0] vx, vy;
      for (i = 0; i < n; i++) begin
         vx = pick_coord(f);
         vy = (f == FLAVOR_LINE) ? vx : pick_coord(f);
         send_vertex(vx, vy, i == n - 1);
      end
   endtask

   // Drop valid and hold until every owed result word is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Result side: check taken words, stall at random, hold off once
   initial begin : result_side
      polygon_result_type got;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.area = rsp_area;
            got.centre_x = rsp_centre_x;
            got.centre_y = rsp_centre_y;
            got.box_centre_x = rsp_box_centre_x;
            got.box_centre_y = rsp_box_centre_y;
            got.box_width = rsp_box_width;
            got.box_height = rsp_box_height;
            got.vertex_total = rsp_vertex_total;
            tracker.check_word(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
         end
      end
   end

   // Stimulus: directed polygons, then random ones
   initial begin : vertex_side
      int random_items;
      int shape;
      int n;
      int pick;
      flavor_type f;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Short polygons at the coordinate extremes
      send_vertex(COORD_MAX, COORD_MIN, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b1);
      // Large triangle and full-range square
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
      // Collinear points and a collapsed point: zero area
      send_vertex(0, 0, 1'b0);
      send_vertex(256, 256, 1'b0);
      send_vertex(512, 512, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(0, 0, 1'b0);
      send_vertex(0, 0, 1'b1);
      // Clockwise square: negative cross sum
      send_vertex(0, 0, 1'b0);
      send_vertex(0, 1024, 1'b0);
      send_vertex(1024, 1024, 1'b0);
      send_vertex(1024, 0, 1'b1);
      // Odd negative box centre and negative mean truncation
      send_vertex(-3, -5, 1'b0);
      send_vertex(0, -1, 1'b0);
      send_vertex(-1, 2, 1'b1);

      random_items = 0;
      shape = 0;
      while (random_items < RANDOM_ITEMS) begin
         // Largest accepted polygon, then one with one to five vertices past the limit
         if (shape == 8) send_polygon(MAX_VERTICES, FLAVOR_FULL);
         if (shape == 30) send_polygon(MAX_VERTICES + $urandom_range(1, 5), FLAVOR_FULL);
         if (shape == 18) hold_request = 1'b1;
         if (shape == 40) drain();
         calm = (shape >= 44 && shape < 54);

         pick = $urandom_range(99);
         if (pick < 8) n = $urandom_range(1, 2);
         else if (pick < 85) n = $urandom_range(3, 8);
         else n = $urandom_range(9, 40);
         pick = $urandom_range(99);
         if (pick < 50) f = FLAVOR_SMALL;
         else if (pick < 75) f = FLAVOR_FULL;
         else if (pick < 88) f = FLAVOR_EDGE;
         else f = FLAVOR_LINE;
         send_polygon(n, f);
         random_items += n;
         shape++;
      end
      calm = 1'b0;

      // Wait out the owed words, then let the block settle
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
design/pabc_pkg.sv
design/pabc_div.sv
design/pabc_ctrl.sv
design/pabc_dp.sv
design/polygon_area_bbox_centroid.sv
test/testbench.sv
